@@ rtl/sur_pkg.sv @@
// ----------------------------------------------------------------------------
// sur_pkg
// Shared types and constants of the serial update receiver.
// ----------------------------------------------------------------------------
package sur_pkg;

	localparam logic [7:0] SYNC0     = 8'hA5;
	localparam logic [7:0] SYNC1     = 8'h5A;
	localparam logic [7:0] CH_BANG   = 8'h21;	// '!'
	localparam logic [7:0] CH_STAR   = 8'h2A;	// '*'
	localparam logic [7:0] CH_HASH   = 8'h23;	// '#'

	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_MAX  = 1'b1;

	typedef enum logic [1:0] {
		K_TX    = 2'd0,
		K_ERASE = 2'd1,
		K_WRITE = 2'd2,
		K_DONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		EM_ACK,
		EM_NAK,
		EM_ERASE,
		EM_WORD,
		EM_DONE
	} emit_t;

	typedef struct packed {
		logic  emit;
		emit_t emit_sel;
		logic  last;
		logic  set_len;
		logic  take_data;
		logic  pk_read;
		logic  pg_copy;
		logic  pg_read;
		logic  pg_clear;
		logic  set_finished;
	} cmd_t;

	typedef struct packed {
		logic pkt_done;
		logic tl_zero;
		logic len_over;
		logic sum_ok;
		logic off_match;
		logic flush;
		logic erase;
		logic complete;
		logic copy_last;
		logic out_free;
	} status_t;

endpackage

@@ rtl/serial_update_receiver.sv @@
// ----------------------------------------------------------------------------
// serial_update_receiver
// Firmware-update link receiver: sync, framing, checksum, paging to flash.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tdata[7:0] rx_byte
//  m_      | out | m_tvalid/m_tready | m_tdata tx/addr/word, m_tuser kind, m_tlast
//  cfg_    | in  | cfg_we            | cfg_index, cfg_wdata
//
//  Bytes that do not end a packet are taken while the sequencer is idle. A
//  packet end runs an evaluation step, a read and a write per data byte
//  copied through the packet memory's registered read port, an erase when
//  due, a read and an emit per flash word on the page memory's single read
//  port, then the ack or nak bytes. After reset a clearing pass fills the
//  PAGE_BYTES/8 page words with 0xFF before the first item is taken. Output
//  stalls hold the sequencer. PAGE_BYTES and SECTOR_BYTES are powers of two.
//
module serial_update_receiver import sur_pkg::*; #(
	parameter int PACKET_BYTES = 16,
	parameter int PAGE_BYTES   = 256,
	parameter int SECTOR_BYTES = 8192
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,	// [7:0] rx_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,	// [7:0] tx_byte, [39:8] flash_address, [103:40] write_word
	output logic [1:0]   m_tuser,	// [1:0] kind
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_wdata
);

	// step counter covers page offsets, word indexes and packet data indexes
	localparam int SW = $clog2(PAGE_BYTES);

	cmd_t          cmd;
	status_t       status;
	logic [SW-1:0] step;
	logic [7:0]    out_tx;
	logic [31:0]   out_addr;
	logic [63:0]   out_word;

	sur_ctrl #(
		.PAGE_BYTES (PAGE_BYTES),
		.SW         (SW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.cmd      (cmd),
		.step     (step),
		.in_ready (s_tready)
	);

	// a byte counts once both sides of the input handshake are high
	sur_datapath #(
		.PACKET_BYTES (PACKET_BYTES),
		.PAGE_BYTES   (PAGE_BYTES),
		.SECTOR_BYTES (SECTOR_BYTES),
		.SW           (SW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_accept (s_tvalid && s_tready),
		.rx_byte   (s_tdata),
		.cmd       (cmd),
		.step      (step),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_tx    (out_tx),
		.out_addr  (out_addr),
		.out_word  (out_word),
		.out_last  (m_tlast)
	);

	assign m_tdata = {out_word, out_addr, out_tx};

endmodule

@@ rtl/sur_datapath.sv @@
// ----------------------------------------------------------------------------
// sur_datapath
// Byte capture, packet and page memories, offset math and result register.
// ----------------------------------------------------------------------------
module sur_datapath import sur_pkg::*; #(
	parameter int PACKET_BYTES = 16,
	parameter int PAGE_BYTES   = 256,
	parameter int SECTOR_BYTES = 8192,
	parameter int SW           = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_wdata,
	input  logic          in_accept,
	input  logic [7:0]    rx_byte,
	input  cmd_t          cmd,
	input  logic [SW-1:0] step,
	output status_t       status,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    out_kind,
	output logic [7:0]    out_tx,
	output logic [31:0]   out_addr,
	output logic [63:0]   out_word,
	output logic          out_last
);

	localparam int BCW = $clog2(PACKET_BYTES + 1);
	localparam int DD  = PACKET_BYTES - 8;
	localparam int DW  = $clog2(DD);
	localparam int LP  = $clog2(PAGE_BYTES);
	localparam int WN  = PAGE_BYTES / 8;
	localparam int WA  = $clog2(WN);
	localparam int SL  = $clog2(SECTOR_BYTES);

	logic [31:0]    base_q, max_q, tl_q, no_q, dst_q;
	logic [BCW-1:0] bc_q, cnt_q, idx, bc1, dlen;
	logic [63:0]    hdr_q;
	logic [7:0]     prev_q, pkt_rd_q;
	logic [15:0]    sum_q;
	logic           finished_q, flush_q, out_valid_q;
	logic [LP-1:0]  pidx_q;
	logic [LP:0]    pos, idx_end;
	logic [63:0]    page_rd_q;
	logic [32:0]    reach;
	logic           sync_bad, done, take;

	logic [7:0]  pkt_mem  [DD];
	logic [63:0] page_mem [WN];

	assign take = in_accept && !finished_q;
	assign dlen = cnt_q - BCW'(8);

	always_comb begin
		idx      = (bc_q >= BCW'(PACKET_BYTES)) ? '0 : bc_q;
		bc1      = idx + BCW'(1);
		sync_bad = (idx == BCW'(1)) && (hdr_q[7:0] != SYNC0 || rx_byte != SYNC1);
		// offset reached by this packet, wrapping at 32 bits
		reach    = {1'b0, no_q + 32'(bc1) - 32'd8};
		done     = !sync_bad && ((tl_q == '0 && bc1 == BCW'(6)) ||
		           (bc1 > BCW'(8) && {1'b0, tl_q} <= reach) ||
		           bc1 >= BCW'(PACKET_BYTES));
		pos      = {1'b0, pidx_q} + (LP+1)'(step);
		idx_end  = {1'b0, no_q[LP-1:0]} + (LP+1)'(dlen);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= 32'd557056;
			max_q      <= 32'd131064;
			bc_q       <= '0;
			tl_q       <= '0;
			no_q       <= '0;
			finished_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BASE: base_q <= cfg_wdata;
					CFG_MAX:  max_q  <= cfg_wdata;
					default:  ;
				endcase
			end
			if (take)
				bc_q <= (sync_bad || done) ? '0 : bc1;
			if (cmd.set_len)
				tl_q <= hdr_q[47:16];
			if (cmd.take_data)
				no_q <= no_q + 32'(dlen);
			if (cmd.set_finished)
				finished_q <= 1'b1;
		end
	end

	// header bytes, running halfword sum, packet length
	always_ff @(posedge clk) begin
		if (take) begin
			prev_q <= rx_byte;
			if (idx < BCW'(8))
				hdr_q[idx[2:0]*8 +: 8] <= rx_byte;
			if (idx == '0)
				sum_q <= '0;
			else if (idx >= BCW'(5) && idx[0])
				sum_q <= sum_q + {rx_byte, prev_q};
			if (done)
				cnt_q <= bc1;
			if (idx >= BCW'(8))
				pkt_mem[DW'(idx - BCW'(8))] <= rx_byte;
		end
		if (cmd.pk_read)
			pkt_rd_q <= pkt_mem[step[DW-1:0]];
		if (cmd.take_data) begin
			pidx_q  <= no_q[LP-1:0];
			flush_q <= (idx_end == (LP+1)'(PAGE_BYTES)) ||
			           (no_q + 32'(dlen) >= tl_q);
			dst_q   <= base_q + {no_q[31:LP], {LP{1'b0}}};
		end
	end

	// page buffer: word wide, byte writes during copy, word clears
	always_ff @(posedge clk) begin
		if (cmd.pg_read)
			page_rd_q <= page_mem[step[WA-1:0]];
		if (cmd.pg_clear)
			page_mem[step[WA-1:0]] <= '1;
		else if (cmd.pg_copy && pos < (LP+1)'(PAGE_BYTES))
			page_mem[pos[LP-1:3]][pos[2:0]*8 +: 8] <= pkt_rd_q;
	end

	always_comb begin
		status.pkt_done  = take && done;
		status.tl_zero   = (tl_q == '0);
		status.len_over  = (hdr_q[47:16] > max_q);
		status.sum_ok    = (sum_q == hdr_q[31:16]);
		status.off_match = (hdr_q[63:32] == no_q);
		status.flush     = flush_q;
		status.erase     = (dst_q[SL-1:0] == '0);
		status.complete  = (no_q >= tl_q);
		status.copy_last = (step == SW'(dlen - BCW'(1)));
		status.out_free  = !out_valid_q || out_ready;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind <= K_TX;
			out_tx   <= '0;
			out_addr <= '0;
			out_word <= '0;
			out_last <= cmd.last;
			unique case (cmd.emit_sel)
				EM_ACK: begin
					unique case (step[2:0])
						3'd0:    out_tx <= CH_HASH;
						3'd1:    out_tx <= no_q[7:0];
						3'd2:    out_tx <= no_q[15:8];
						3'd3:    out_tx <= no_q[23:16];
						default: out_tx <= no_q[31:24];
					endcase
				end
				EM_NAK:   out_tx <= (step[1:0] == 2'd3) ? CH_STAR : CH_BANG;
				EM_ERASE: begin
					out_kind <= K_ERASE;
					out_addr <= dst_q;
				end
				EM_WORD: begin
					out_kind <= K_WRITE;
					out_addr <= dst_q + {(32-SW-3)'(0), step, 3'b000};
					out_word <= page_rd_q;
				end
				EM_DONE:  out_kind <= K_DONE;
				default:  ;
			endcase
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free) else $error("result overwritten");
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q) else $error("finished flag dropped");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && finished_q) |=> $stable(bc_q)) else $error("byte taken after finish");
	a_len_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_len |-> tl_q == '0) else $error("length set twice");
`endif

endmodule

@@ rtl/sur_ctrl.sv @@
// ----------------------------------------------------------------------------
// sur_ctrl
// Sequencer: clear sweep, packet evaluation, copy, flush, ack and nak emission, completion.
// ----------------------------------------------------------------------------
module sur_ctrl import sur_pkg::*; #(
	parameter int PAGE_BYTES = 256,
	parameter int SW         = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  status_t       status,
	output cmd_t          cmd,
	output logic [SW-1:0] step,
	output logic          in_ready
);

	localparam int WN = PAGE_BYTES / 8;

	typedef enum logic [10:0] {
		S_CLEAR   = 11'b00000000001,
		S_IDLE    = 11'b00000000010,
		S_EVAL    = 11'b00000000100,
		S_COPY_RD = 11'b00000001000,
		S_COPY_WR = 11'b00000010000,
		S_ERASE   = 11'b00000100000,
		S_FL_RD   = 11'b00001000000,
		S_FL_EMIT = 11'b00010000000,
		S_ACK     = 11'b00100000000,
		S_NAK     = 11'b01000000000,
		S_FIN     = 11'b10000000000
	} state_t;

	state_t        state_q, state_d;
	logic [SW-1:0] step_q, step_d;
	logic          chk_q, chk_d;
	logic          word_last;

	assign word_last = (step_q == SW'(WN - 1));

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		chk_d   = chk_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.pg_clear = 1'b1;
				step_d = step_q + SW'(1);
				if (word_last) begin
					step_d  = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (status.pkt_done)
					state_d = S_EVAL;
			end
			S_EVAL: begin
				step_d = '0;
				chk_d  = 1'b0;
				if (status.tl_zero) begin
					if (status.len_over)
						state_d = S_NAK;
					else begin
						cmd.set_len = 1'b1;
						state_d = S_ACK;
					end
				end else if (!status.sum_ok)
					state_d = S_ACK;
				else if (status.off_match) begin
					cmd.take_data = 1'b1;
					chk_d   = 1'b1;
					state_d = S_COPY_RD;
				end else begin
					chk_d   = 1'b1;
					state_d = S_ACK;
				end
			end
			S_COPY_RD: begin
				cmd.pk_read = 1'b1;
				state_d = S_COPY_WR;
			end
			S_COPY_WR: begin
				cmd.pg_copy = 1'b1;
				if (status.copy_last) begin
					step_d = '0;
					if (!status.flush)
						state_d = S_ACK;
					else if (status.erase)
						state_d = S_ERASE;
					else
						state_d = S_FL_RD;
				end else begin
					step_d  = step_q + SW'(1);
					state_d = S_COPY_RD;
				end
			end
			S_ERASE: begin
				if (status.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_ERASE;
					state_d      = S_FL_RD;
				end
			end
			S_FL_RD: begin
				cmd.pg_read = 1'b1;
				state_d = S_FL_EMIT;
			end
			S_FL_EMIT: begin
				if (status.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_WORD;
					cmd.pg_clear = 1'b1;
					if (word_last) begin
						step_d  = '0;
						state_d = S_ACK;
					end else begin
						step_d  = step_q + SW'(1);
						state_d = S_FL_RD;
					end
				end
			end
			S_ACK: begin
				if (status.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_ACK;
					cmd.last     = (step_q == SW'(4)) && !(chk_q && status.complete);
					step_d       = step_q + SW'(1);
					if (step_q == SW'(4)) begin
						step_d  = '0;
						state_d = (chk_q && status.complete) ? S_FIN : S_IDLE;
					end
				end
			end
			S_NAK: begin
				if (status.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_NAK;
					cmd.last     = (step_q == SW'(3));
					step_d       = step_q + SW'(1);
					if (step_q == SW'(3)) begin
						step_d  = '0;
						state_d = S_IDLE;
					end
				end
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.emit         = 1'b1;
					cmd.emit_sel     = EM_DONE;
					cmd.last         = 1'b1;
					cmd.set_finished = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			step_q  <= '0;
			chk_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			chk_q   <= chk_d;
		end
	end

	assign step     = step_q;
	assign in_ready = (state_q == S_IDLE);

`ifndef ASSERT_OFF
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !status.pkt_done) else $error("byte taken while busy");
	a_eval_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |=> (state_q != S_EVAL)) else $error("evaluation repeated");
	a_fin_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> chk_q) else $error("completion without data packet");
`endif

endmodule

@@ dv/serial_update_receiver_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_update_receiver_test
// Self-checking bench for the firmware-update link receiver: feeds framed
// byte packets (sync, length, checksummed data, noise, corrupt packets),
// predicts acks, naks, erases, word writes and the completion trigger, and
// compares every output item in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module serial_update_receiver_test;
	import sur_pkg::*;

	localparam int PKT_LEN   = 16;
	localparam int PAGE_LEN  = 256;
	localparam int SECTOR_LEN = 8192;
	localparam int STALL_LIMIT = 5000;	// cycles without any handshake
	localparam int HOLD_CYCLES = 400;	// long receiver hold-off

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tx;
		logic [31:0] addr;
		logic [63:0] word;
		logic        last;
	} flash_op_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;	// [7:0] rx_byte
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;	// [7:0] tx_byte, [39:8] flash_address, [103:40] write_word
	logic [1:0]   m_tuser;	// [1:0] kind
	logic         m_tlast;
	logic         cfg_we;
	logic         cfg_index;
	logic [31:0]  cfg_wdata;

	serial_update_receiver dut (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// ---------------- receiver model ----------------
	logic [31:0] base_addr, max_len;
	logic [7:0]  rx_pkt [PKT_LEN];
	int          rx_cnt;
	logic [31:0] image_len, next_off;
	logic [7:0]  page_buf [PAGE_LEN];
	logic        image_done;

	flash_op_t   expected_ops [$];
	logic [7:0]  rx_bytes [$];	// items waiting for the driver

	int errors, ops_seen, flushes_seen;
	bit quiet, hold_req;

	function automatic void push_op(kind_t k, logic [7:0] tx, logic [31:0] a, logic [63:0] w);
		flash_op_t op;
		op.kind = k;
		op.tx   = tx;
		op.addr = a;
		op.word = w;
		op.last = 1'b0;
		expected_ops.push_back(op);
	endfunction

	function automatic void push_ack(logic [31:0] off);
		push_op(K_TX, CH_HASH, '0, '0);
		for (int i = 0; i < 4; i++)
			push_op(K_TX, off[8*i +: 8], '0, '0);
	endfunction

	function automatic logic [31:0] pkt_word(int at);
		return {rx_pkt[at+3], rx_pkt[at+2], rx_pkt[at+1], rx_pkt[at]};
	endfunction

	function automatic void flush_page(logic [31:0] dst);
		logic [63:0] w;
		if (dst % SECTOR_LEN == 0)
			push_op(K_ERASE, '0, dst, '0);
		for (int k = 0; k < PAGE_LEN / 8; k++) begin
			for (int b = 0; b < 8; b++)
				w[8*b +: 8] = page_buf[k*8 + b];
			push_op(K_WRITE, '0, dst + 32'(k * 8), w);
		end
		foreach (page_buf[i])
			page_buf[i] = 8'hFF;
	endfunction

	function automatic void close_packet();
		int cnt;
		logic [15:0] sum, want;
		logic [31:0] len, off, dlen, idx;
		cnt = rx_cnt;
		rx_cnt = 0;
		if (image_len == 0) begin
			len = pkt_word(2);
			if (len > max_len) begin
				push_op(K_TX, CH_BANG, '0, '0);
				push_op(K_TX, CH_BANG, '0, '0);
				push_op(K_TX, CH_BANG, '0, '0);
				push_op(K_TX, CH_STAR, '0, '0);
				return;
			end
			image_len = len;
			push_ack('0);
			return;
		end
		sum = '0;
		want = {rx_pkt[3], rx_pkt[2]};
		for (int i = 0; i < (cnt - 4) / 2; i++)
			sum = sum + {rx_pkt[5 + 2*i], rx_pkt[4 + 2*i]};
		if (sum != want) begin
			push_ack(next_off);
			return;
		end
		off = pkt_word(4);
		if (off == next_off) begin
			dlen = 32'(cnt - 8);
			idx = off % PAGE_LEN;
			for (int j = 0; j < dlen; j++)
				if (idx + j < PAGE_LEN)
					page_buf[idx + j] = rx_pkt[8 + j];
			idx = idx + dlen;
			if (idx == PAGE_LEN || next_off + dlen >= image_len)
				flush_page(base_addr + off + dlen - idx);
			next_off = next_off + dlen;
		end
		push_ack(next_off);
		if (next_off >= image_len) begin
			push_op(K_DONE, '0, '0, '0);
			image_done = 1'b1;
		end
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		int n0;
		bit done;
		n0 = expected_ops.size();
		if (image_done)
			return;
		if (rx_cnt >= PKT_LEN)
			rx_cnt = 0;
		rx_pkt[rx_cnt] = b;
		rx_cnt++;
		if (rx_cnt < 2)
			return;
		if (rx_cnt == 2) begin
			if (rx_pkt[0] != SYNC0 || rx_pkt[1] != SYNC1)
				rx_cnt = 0;
			return;
		end
		done = (image_len == 0 && rx_cnt == 6)
			|| (rx_cnt > 8 && image_len <= 32'(rx_cnt - 8) + next_off)
			|| rx_cnt >= PKT_LEN;
		if (done)
			close_packet();
		if (expected_ops.size() > n0)
			expected_ops[$].last = 1'b1;
	endfunction

	// ---------------- driver ----------------
	int src_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (rx_bytes.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= rx_bytes.pop_front();
					if (!quiet && $urandom_range(0, 7) == 0)
						src_gap = $urandom_range(1, 9);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor and scoreboard ----------------
	int sink_stall, hold_left;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		flash_op_t want, got;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_stall = 0;
			hold_left = 0;
			hold_done = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind = kind_t'(m_tuser);
				got.tx   = m_tdata[7:0];
				got.addr = m_tdata[39:8];
				got.word = m_tdata[103:40];
				got.last = m_tlast;
				ops_seen++;
				if (got.kind == K_WRITE)
					flushes_seen++;
				if (expected_ops.size() == 0) begin
					errors++;
					$display("%0t: unexpected item kind=%0d tx=%h addr=%h word=%h last=%b",
						$time, got.kind, got.tx, got.addr, got.word, got.last);
				end else begin
					want = expected_ops.pop_front();
					if (got.kind != want.kind) begin
						errors++;
						$display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
					end
					if (got.tx != want.tx) begin
						errors++;
						$display("%0t: tx_byte expected %h actual %h", $time, want.tx, got.tx);
					end
					if (got.addr != want.addr) begin
						errors++;
						$display("%0t: flash_address expected %h actual %h",
							$time, want.addr, got.addr);
					end
					if (got.word != want.word) begin
						errors++;
						$display("%0t: write_word expected %h actual %h",
							$time, want.word, got.word);
					end
					if (got.last != want.last) begin
						errors++;
						$display("%0t: last expected %b actual %b", $time, want.last, got.last);
					end
				end
			end
			// ready pattern: one long hold-off on request, else random bursts
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (sink_stall > 0) begin
				sink_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0)
					sink_stall = $urandom_range(1, 9);
			end
		end
	end

	// ---------------- watchdog ----------------
	int idle_cycles;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	logic [31:0] gen_off;	// offset the generator believes is next

	task automatic wait_drained();
		wait (rx_bytes.size() == 0 && !s_tvalid && expected_ops.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == CFG_BASE)
			base_addr = val;
		else
			max_len = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_len(logic [31:0] len);
		rx_bytes.push_back(SYNC0);
		rx_bytes.push_back(SYNC1);
		for (int i = 0; i < 4; i++)
			rx_bytes.push_back(len[8*i +: 8]);
	endtask

	// fill: 0 random, 1 all zeros, 2 all ones
	task automatic send_data(logic [31:0] off, bit bad_sum, int fill);
		logic [7:0]  pk [PKT_LEN];
		logic [15:0] sum;
		logic [31:0] left;
		int dlen, cnt;
		left = image_len - gen_off;
		dlen = (left < 8) ? int'(left) : 8;
		cnt = 8 + dlen;
		pk[0] = SYNC0;
		pk[1] = SYNC1;
		for (int i = 0; i < 4; i++)
			pk[4 + i] = off[8*i +: 8];
		for (int i = 8; i < cnt; i++)
			pk[i] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
		sum = '0;
		for (int i = 0; i < (cnt - 4) / 2; i++)
			sum = sum + {pk[5 + 2*i], pk[4 + 2*i]};
		if (bad_sum)
			sum = sum ^ 16'(1 << $urandom_range(0, 15));
		pk[2] = sum[7:0];
		pk[3] = sum[15:8];
		for (int i = 0; i < cnt; i++)
			rx_bytes.push_back(pk[i]);
		if (!bad_sum && off == gen_off)
			gen_off = gen_off + 32'(dlen);
	endtask

	task automatic send_noise_pair();
		logic [7:0] a;
		a = 8'($urandom);
		if (a == SYNC0)
			a = 8'h00;
		rx_bytes.push_back(a);
		rx_bytes.push_back(8'($urandom));
	endtask

	initial begin
		int r;
		bit base_moved;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BASE;
		cfg_wdata = '0;
		errors = 0;
		ops_seen = 0;
		flushes_seen = 0;
		quiet = 0;
		hold_req = 0;
		base_moved = 0;
		base_addr = 32'd557056;
		max_len = 32'd131064;
		rx_cnt = 0;
		image_len = '0;
		next_off = '0;
		image_done = 1'b0;
		gen_off = '0;
		foreach (page_buf[i])
			page_buf[i] = 8'hFF;
		foreach (rx_pkt[i])
			rx_pkt[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed: sync rejection, length limits, corrupt packets ----
		write_reg(CFG_MAX, 32'h0000_0000);
		rx_bytes.push_back(8'h00);	// non-sync pair
		rx_bytes.push_back(8'h00);
		rx_bytes.push_back(SYNC0);	// good first sync byte, bad second
		rx_bytes.push_back(8'hA5);
		rx_bytes.push_back(8'hFF);	// bad first, good second
		rx_bytes.push_back(SYNC1);
		send_len(32'd1);	// above a zero limit: rejected
		send_len(32'd0);	// zero length: acked, still waiting for a length
		wait_drained();
		write_reg(CFG_MAX, 32'hFFFF_FFFE);
		send_len(32'hFFFF_FFFF);	// one above the limit: rejected
		// image length, mostly not a whole number of packets
		r = $urandom_range(170, 190);
		send_len(32'(r));

		wait_drained();
		write_reg(CFG_BASE, 32'hFFFF_FF00);
		gen_off = next_off;
		send_data(gen_off, 0, 1);
		send_data(gen_off, 0, 2);
		send_data(gen_off, 1, 0);	// checksum error
		send_data(gen_off + 32'd8, 0, 0);	// out-of-order offset
		send_data(32'hFFFF_FFFF, 0, 0);	// wild offset
		send_noise_pair();
		send_data(gen_off, 0, 0);

		// ---- random: mostly good packets, some corrupt ones and noise ----
		while (gen_off < 32'(r)) begin
			if (!hold_req && gen_off >= 32'd48) begin
				hold_req = 1;
				for (int i = 0; i < 12; i++)
					send_data(gen_off, 0, 0);
			end
			if (!base_moved && gen_off >= 32'd96) begin
				base_moved = 1;
				wait_drained();
				write_reg(CFG_BASE, 32'h0000_0000);	// final page on a sector boundary
				write_reg(CFG_MAX, 32'($urandom));
			end
			if (gen_off + 32'd64 >= 32'(r))
				quiet = 1;
			case ($urandom_range(0, 19))
				0: send_data(gen_off, 1, 0);
				1: send_data(gen_off + 32'(8 * $urandom_range(1, 40)), 0, 0);
				2: send_noise_pair();
				default: send_data(gen_off, 0, $urandom_range(0, 15) == 0 ? 2 : 0);
			endcase
			wait (rx_bytes.size() < 64);
		end
		// bytes after completion are ignored
		send_noise_pair();
		send_noise_pair();
		wait_drained();
		$display("Ran %0d bytes of image data; %0d output items checked, %0d word writes.",
			gen_off, ops_seen, flushes_seen);
		$display("Covered sync rejects, length limits, bad checksums, stray offsets, stalls.");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
